FILE: hdl/multichannel_pulse_width_capture_defines.svh
// Assertion macros for the checker file of the pulse width capture block.
`ifndef MULTICHANNEL_PULSE_WIDTH_CAPTURE_DEFINES_SVH
`define MULTICHANNEL_PULSE_WIDTH_CAPTURE_DEFINES_SVH

// Implication checked on every clock edge outside reset.
`define MPWC_ASSERT_IMPL(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Property checked on every clock edge, reset included.
`define MPWC_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

FILE: hdl/mpwc_pkg.sv
`default_nettype none

package mpwc_pkg;

   localparam int CHANNELS   = 5;
   localparam int PIN_W      = 5;
   localparam int COUNT_W    = 16;
   localparam int CH_FIELD_W = 3;
   localparam int CH_IDX_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

   localparam int REQ_FIELDS_W = COUNT_W + PIN_W;
   localparam int REQ_TDATA_W  = ((REQ_FIELDS_W + 7) / 8) * 8;
   localparam int RSP_FIELDS_W = CH_FIELD_W + COUNT_W;
   localparam int RSP_TDATA_W  = ((RSP_FIELDS_W + 7) / 8) * 8;

   localparam int CSR_INDEX_W = 1;
   localparam logic [CSR_INDEX_W-1:0] CSR_PERIOD_COUNT = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_WIDTH_LIMIT  = 1'd1;

   localparam logic [COUNT_W-1:0] PERIOD_RESET = 16'd2500;
   localparam logic [COUNT_W-1:0] LIMIT_RESET  = 16'd2100;

   typedef struct packed {
      logic [COUNT_W-1:0] period_count;
      logic [COUNT_W-1:0] width_limit;
   } cfg_type;

   typedef struct packed {
      logic               emit;
      logic [COUNT_W-1:0] pulse_width;
   } chan_result_type;

endpackage

`default_nettype wire

FILE: hdl/multichannel_pulse_width_capture.sv
// Multichannel pulse width capture.
// The req channel carries one sample per transfer: a timer count and one
// level bit per channel. A sample whose count is exactly one above the last
// accepted count is dropped. A rising level stores the count as the start
// stamp; a falling level yields (count - start, plus the period on wrap) * 4,
// sent on the rsp channel with its channel number when below the width limit.
// Results of one sample leave in ascending channel order, tlast on the last.
// With nothing pending, a sample's first result passes the input register, the
// mask and width registers and then the rsp register. Results drain one per
// cycle through the rsp register while the rsp receiver is ready; the next
// sample waits in the input register until the last result is popped. With no
// result nothing waits, so one sample per cycle is taken while no pulse ends.
// The csr channel is always ready and writes period_count (index 0) or
// width_limit (index 1); write it only while the block is idle.
// Reset restores the register defaults, clears all channel levels and the
// last count, and empties the pipeline. When the rsp receiver stalls, the
// pending results wait and req_tready falls once the input register is full.
`default_nettype none

module multichannel_pulse_width_capture
   import mpwc_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_tvalid,
   output logic                        req_tready,
   // sample_count [15:0], pin_levels [20:16], zero pad above
   input  wire logic [REQ_TDATA_W-1:0] req_tdata,
   output logic                        rsp_tvalid,
   input  wire logic                   rsp_tready,
   // channel [2:0], pulse_width [18:3], zero pad above
   output logic [RSP_TDATA_W-1:0]      rsp_tdata,
   output logic                        rsp_tlast,
   input  wire logic                   csr_valid,
   output logic                        csr_ready,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [COUNT_W-1:0]     csr_data
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   logic               in_valid_ff;
   logic               in_valid_in;
   logic [COUNT_W-1:0] in_count_ff;
   logic [PIN_W-1:0]   in_levels_ff;
   logic [COUNT_W-1:0] last_count_ff;
   logic [COUNT_W-1:0] last_count_in;

   logic [CHANNELS-1:0] mask_ff;
   logic [CHANNELS-1:0] mask_in;
   logic [COUNT_W-1:0]  width_ff [CHANNELS];

   logic                  rsp_valid_ff;
   logic                  rsp_valid_in;
   logic [CH_FIELD_W-1:0] rsp_channel_ff;
   logic [COUNT_W-1:0]    rsp_width_ff;
   logic                  rsp_last_ff;

   logic                  req_fire;
   logic                  skip;
   logic                  advance;
   logic                  commit;
   logic                  rsp_load;
   logic                  pop;
   logic [CHANNELS-1:0]   pick_oh;
   logic [CH_IDX_W-1:0]   pick;
   logic [CHANNELS-1:0]   mask_rest;
   logic [CHANNELS-1:0]   mask_after;
   logic [CHANNELS-1:0]   lvl_vec;
   logic [CHANNELS-1:0]   emit_vec;
   chan_result_type       chan_res [CHANNELS];

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_PERIOD_COUNT: cfg_in.period_count = csr_data;
            CSR_WIDTH_LIMIT:  cfg_in.width_limit  = csr_data;
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   // The skip test compares without wrap, so a count of zero after the
   // largest count is always taken.
   assign skip = ({1'b0, in_count_ff} == ({1'b0, last_count_ff} + 17'd1));

   assign rsp_load  = !rsp_valid_ff || rsp_tready;
   assign pick_oh   = mask_ff & (~mask_ff + {{(CHANNELS-1){1'b0}}, 1'b1});
   assign mask_rest = mask_ff & ~pick_oh;
   assign pop       = (|mask_ff) && rsp_load;
   assign mask_after = pop ? mask_rest : mask_ff;

   always_comb begin
      pick = '0;
      for (int i = 0; i < CHANNELS; i++) begin
         if (pick_oh[i]) begin
            pick = CH_IDX_W'(i);
         end
      end
   end

   assign advance    = in_valid_ff && (mask_after == '0);
   assign commit     = advance && !skip;
   assign req_tready = !in_valid_ff || advance;
   assign req_fire   = req_tvalid && req_tready;

   for (genvar g = 0; g < CHANNELS; g++) begin : g_chan
      if (g < PIN_W) begin : g_pin
         assign lvl_vec[g] = in_levels_ff[g];
      end else begin : g_nopin
         assign lvl_vec[g] = 1'b0;
      end

      mpwc_channel u_channel (
         .clock        (clock),
         .reset        (reset),
         .commit       (commit),
         .sample_count (in_count_ff),
         .level        (lvl_vec[g]),
         .cfg          (cfg_ff),
         .result       (chan_res[g])
      );

      assign emit_vec[g] = chan_res[g].emit;
   end

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_fire) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
      last_count_in = commit ? in_count_ff : last_count_ff;
      mask_in = mask_after;
      if (advance) begin
         mask_in = commit ? emit_vec : '0;
      end
      rsp_valid_in = rsp_load ? pop : rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.period_count <= PERIOD_RESET;
         cfg_ff.width_limit  <= LIMIT_RESET;
         in_valid_ff   <= 1'b0;
         last_count_ff <= '0;
         mask_ff       <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         cfg_ff        <= cfg_in;
         in_valid_ff   <= in_valid_in;
         last_count_ff <= last_count_in;
         mask_ff       <= mask_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_count_ff  <= req_tdata[COUNT_W-1:0];
         in_levels_ff <= req_tdata[COUNT_W +: PIN_W];
      end
      if (advance) begin
         for (int i = 0; i < CHANNELS; i++) begin
            width_ff[i] <= chan_res[i].pulse_width;
         end
      end
      if (pop) begin
         rsp_channel_ff <= CH_FIELD_W'(pick);
         rsp_width_ff   <= width_ff[pick];
         rsp_last_ff    <= (mask_rest == '0);
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tdata  = {{(RSP_TDATA_W-RSP_FIELDS_W){1'b0}}, rsp_width_ff, rsp_channel_ff};

endmodule

`default_nettype wire

FILE: hdl/mpwc_channel.sv
`default_nettype none

module mpwc_channel
   import mpwc_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               commit,
   input  wire logic [COUNT_W-1:0] sample_count,
   input  wire logic               level,
   input  wire cfg_type            cfg,
   output chan_result_type         result
);

   logic               level_ff;
   logic               level_in;
   logic [COUNT_W-1:0] stamp_ff;
   logic [COUNT_W-1:0] stamp_in;

   logic               rising;
   logic               falling;
   logic signed [COUNT_W+1:0] diff;
   logic signed [COUNT_W+1:0] adj;
   logic [COUNT_W+1:0] scaled;

   assign rising  = !level_ff && level;
   assign falling = level_ff && !level;

   always_comb begin
      diff = $signed({2'b00, sample_count}) - $signed({2'b00, stamp_ff});
      // A negative difference means the timer wrapped during the pulse.
      adj  = diff[COUNT_W+1] ? diff + $signed({2'b00, cfg.period_count}) : diff;
      scaled = {adj[COUNT_W-1:0], 2'b00};
      result.emit = falling && !adj[COUNT_W+1] && (scaled < {2'b00, cfg.width_limit});
      result.pulse_width = scaled[COUNT_W-1:0];
   end

   always_comb begin
      level_in = level_ff;
      stamp_in = stamp_ff;
      if (commit) begin
         level_in = level;
         if (rising) begin
            stamp_in = sample_count;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         level_ff <= 1'b0;
      end else begin
         level_ff <= level_in;
      end
      stamp_ff <= stamp_in;
   end

endmodule

`default_nettype wire

FILE: hdl/mpwc_checker.sv
`default_nettype none
`include "multichannel_pulse_width_capture_defines.svh"

module mpwc_checker
   import mpwc_pkg::*;
(
   input wire logic                   clock,
   input wire logic                   reset,
   input wire logic                   rsp_tvalid,
   input wire logic                   rsp_tready,
   input wire logic [RSP_TDATA_W-1:0] rsp_tdata,
   input wire logic                   rsp_tlast
);

   logic                 rsp_stall;
   logic [RSP_TDATA_W:0] rsp_payload;
   logic                 chan_ok;
   logic                 width_ok;

   assign rsp_stall   = rsp_tvalid && !rsp_tready;
   assign rsp_payload = {rsp_tlast, rsp_tdata};
   assign chan_ok     = (rsp_tdata[CH_FIELD_W-1:0] < CH_FIELD_W'(CHANNELS));
   // The width is a count times four, so its two low bits stay clear.
   assign width_ok    = (rsp_tdata[CH_FIELD_W +: 2] == 2'b00);

   `MPWC_ASSERT_IMPL(a_rsp_hold, rsp_stall |=> rsp_tvalid && $stable(rsp_payload), "rsp not held")
   `MPWC_ASSERT_ALWAYS(a_rsp_reset, !reset && $past(reset) |-> !rsp_tvalid, "rsp busy at reset")
   `MPWC_ASSERT_IMPL(a_channel_range, rsp_tvalid |-> chan_ok, "rsp channel out of range")
   `MPWC_ASSERT_IMPL(a_width_scaled, rsp_tvalid |-> width_ok, "pulse width not a multiple of four")

endmodule

bind multichannel_pulse_width_capture mpwc_checker u_mpwc_checker (.*);

`default_nettype wire

FILE: tb/sv/pulse_width_sb_pkg.sv
`timescale 1ns / 1ps

package pulse_width_sb_pkg;
   import mpwc_pkg::*;

   typedef struct packed {
      logic [CH_FIELD_W-1:0] channel;
      logic [COUNT_W-1:0]    pulse_width;
      logic                  last;
   } pulse_result_type;

   class pulse_width_scoreboard;
      logic [COUNT_W-1:0] period_count;
      logic [COUNT_W-1:0] width_limit;
      logic [COUNT_W-1:0] last_count;
      logic               chan_level [CHANNELS];
      logic [COUNT_W-1:0] start_stamp [CHANNELS];
      pulse_result_type   expected_widths [$];
      int                 mismatches;

      function new();
         period_count = PERIOD_RESET;
         width_limit  = LIMIT_RESET;
         last_count   = '0;
         for (int ch = 0; ch < CHANNELS; ch++) begin
            chan_level[ch]  = 1'b0;
            start_stamp[ch] = '0;
         end
         mismatches = 0;
      endfunction

      function void set_register(input logic [CSR_INDEX_W-1:0] index,
                                 input logic [COUNT_W-1:0] value);
         case (index)
            CSR_PERIOD_COUNT: period_count = value;
            CSR_WIDTH_LIMIT:  width_limit  = value;
            default: ;
         endcase
      endfunction

      function int pending();
         return expected_widths.size();
      endfunction

      // Updates the capture state for one sample and queues the widths it
      // completes. Returns 0 when the sample is dropped by the skip test.
      function bit note_sample(input logic [COUNT_W-1:0] count,
                               input logic [PIN_W-1:0] levels);
         pulse_result_type found [CHANNELS];
         pulse_result_type item;
         int               n;
         int               diff;
         int               scaled;
         logic             lvl;
         // The skip test compares without wrap, so 0 after 65535 is taken.
         if ({1'b0, count} == {1'b0, last_count} + 17'd1)
            return 1'b0;
         last_count = count;
         n = 0;
         for (int ch = 0; ch < CHANNELS; ch++) begin
            lvl = (ch < PIN_W) ? levels[ch] : 1'b0;
            if (!chan_level[ch] && lvl) begin
               chan_level[ch]  = 1'b1;
               start_stamp[ch] = count;
            end else if (chan_level[ch] && !lvl) begin
               chan_level[ch] = 1'b0;
               diff = int'(count) - int'(start_stamp[ch]);
               if (diff < 0)
                  diff = diff + int'(period_count);
               // A difference that stays negative is dropped silently.
               if (diff >= 0) begin
                  scaled = diff * 4;
                  if (scaled < int'(width_limit)) begin
                     found[n].channel     = CH_FIELD_W'(ch);
                     found[n].pulse_width = COUNT_W'(scaled);
                     found[n].last        = 1'b0;
                     n++;
                  end
               end
            end
         end
         for (int k = 0; k < n; k++) begin
            item = found[k];
            item.last = (k == n - 1);
            expected_widths.push_back(item);
         end
         return 1'b1;
      endfunction

      task report_mismatch(input string msg);
         $display("%0t: MISMATCH %s", $time, msg);
         mismatches++;
      endtask

      task check_result(input logic [CH_FIELD_W-1:0] channel,
                        input logic [COUNT_W-1:0] pulse_width,
                        input logic last);
         pulse_result_type want;
         if (expected_widths.size() == 0) begin
            report_mismatch($sformatf("unexpected result channel %0d width %0d last %0b",
                                      channel, pulse_width, last));
            return;
         end
         want = expected_widths.pop_front();
         if (channel !== want.channel)
            report_mismatch($sformatf("channel got %0d want %0d", channel, want.channel));
         if (pulse_width !== want.pulse_width)
            report_mismatch($sformatf("pulse_width on channel %0d got %0d want %0d",
                                      want.channel, pulse_width, want.pulse_width));
         if (last !== want.last)
            report_mismatch($sformatf("last on channel %0d got %0b want %0b",
                                      want.channel, last, want.last));
      endtask
   endclass

endpackage

FILE: tb/sv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
   import mpwc_pkg::*;
   import pulse_width_sb_pkg::*;

   localparam int CLK_PERIOD      = 10;
   localparam int RESET_CYCLES    = 5;
   localparam int DRAIN_CYCLES    = 8;
   localparam int WATCHDOG_LIMIT  = 2000;
   localparam int PHASES          = 6;
   localparam int ITEMS_PER_PHASE = 58;

   logic                   clock      = 1'b0;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata  = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic                   rsp_tlast;
   logic                   csr_valid  = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index  = CSR_PERIOD_COUNT;
   logic [COUNT_W-1:0]     csr_data   = '0;

   int send_idle = 19;
   int recv_idle = 71;
   int stall_cycles = 0;

   pulse_width_scoreboard sb = new();

   multichannel_pulse_width_capture dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always #(CLK_PERIOD / 2) clock = ~clock;

   // Result side: check each transfer and draw a new ready every cycle.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         sb.check_result(rsp_tdata[CH_FIELD_W-1:0], rsp_tdata[CH_FIELD_W +: COUNT_W],
                         rsp_tlast);
      rsp_tready <= ($urandom_range(0, 99) >= recv_idle);
   end

   always @(posedge clock) begin
      if (!reset) begin
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
             (csr_valid && csr_ready))
            stall_cycles <= 0;
         else
            stall_cycles <= stall_cycles + 1;
         if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("Test completed with failures");
            $finish;
         end
      end
   end

   // Holds one sample on the input until its transfer, then maybe idles.
   task automatic send_sample(input logic [COUNT_W-1:0] cnt, input logic [PIN_W-1:0] lv,
                              output bit taken);
      req_tvalid <= 1'b1;
      req_tdata  <= REQ_TDATA_W'({lv, cnt});
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      taken = sb.note_sample(cnt, lv);
      if ($urandom_range(0, 99) < send_idle) begin
         req_tvalid <= 1'b0;
         do @(posedge clock); while ($urandom_range(0, 99) < send_idle);
      end
   endtask

   // Stops sending until every expected result is out and the pipeline is empty.
   task automatic settle();
      req_tvalid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic configure(input logic [COUNT_W-1:0] period, input logic [COUNT_W-1:0] limit);
      csr_valid <= 1'b1;
      csr_index <= CSR_PERIOD_COUNT;
      csr_data  <= period;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      sb.set_register(CSR_PERIOD_COUNT, period);
      csr_index <= CSR_WIDTH_LIMIT;
      csr_data  <= limit;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      sb.set_register(CSR_WIDTH_LIMIT, limit);
      csr_valid <= 1'b0;
   endtask

   initial begin
      logic [COUNT_W-1:0] cnt;
      logic [PIN_W-1:0]   lv;
      logic [PIN_W-1:0]   lv_state;
      logic [COUNT_W-1:0] period_sel;
      logic [COUNT_W-1:0] limit_sel;
      bit                 taken;
      int                 total;
      int                 done;
      int                 tmr;
      int                 wrap;
      int                 stride;
      int                 r;

      total    = 0;
      lv_state = '0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed samples under the reset register values.
      send_sample(16'd0, 5'b00000, taken);      // count 0 right after reset is taken
      send_sample(16'd1, 5'b11111, taken);      // one above the last count: dropped
      send_sample(16'd5, 5'b11111, taken);      // all channels rise
      send_sample(16'd6, 5'b00000, taken);      // dropped again
      send_sample(16'd10, 5'b00000, taken);     // all five channels complete at once
      send_sample(16'd100, 5'b10101, taken);
      send_sample(16'd624, 5'b10100, taken);    // just below the limit
      send_sample(16'd50, 5'b00100, taken);     // wraps, then too wide
      send_sample(16'd625, 5'b00000, taken);    // exactly at the limit
      send_sample(16'd65535, 5'b11111, taken);
      send_sample(16'd0, 5'b00000, taken);      // still negative after the period
      send_sample(16'd1, 5'b11111, taken);
      send_sample(16'd2, 5'b11111, taken);
      send_sample(16'd2, 5'b00000, taken);      // zero width on every channel
      send_sample(16'd40000, 5'b01010, taken);
      send_sample(16'd40130, 5'b10001, taken);
      send_sample(16'd40300, 5'b00000, taken);

      for (int ph = 0; ph < PHASES; ph++) begin
         settle();
         case (ph)
            0: begin period_sel = 16'd2500;  limit_sel = 16'd2100;  end
            1: begin period_sel = 16'd65535; limit_sel = 16'd65535; end
            2: begin period_sel = 16'd1;     limit_sel = 16'd0;     end
            3: begin period_sel = 16'd1;     limit_sel = 16'd65535; end
            4: begin
               period_sel = COUNT_W'($urandom_range(64, 5000));
               limit_sel  = COUNT_W'($urandom_range(100, 8000));
            end
            default: begin period_sel = 16'd300; limit_sel = 16'd1200; end
         endcase
         configure(period_sel, limit_sel);
         // Small periods would pin the timer, so it then runs over the full count range.
         wrap   = (period_sel >= 64) ? int'(period_sel) : 65536;
         stride = (period_sel >= 64) ? int'(period_sel) / 8 : 400;
         tmr    = 0;
         done   = 0;
         while (done < ITEMS_PER_PHASE) begin
            if (total < 128) begin
               send_idle = 19;
               recv_idle = 71;
            end else if (total < 256) begin
               send_idle = 71;
               recv_idle = 19;
            end else begin
               send_idle = 0;
               recv_idle = 0;
            end
            r = $urandom_range(0, 99);
            if (r < 8) begin
               cnt = COUNT_W'($urandom);
               lv  = PIN_W'($urandom);
            end else if (r < 14) begin
               cnt = sb.last_count + 1'b1;
               lv  = PIN_W'($urandom);
            end else begin
               tmr = (tmr + $urandom_range(2, stride)) % wrap;
               cnt = COUNT_W'(tmr);
               for (int b = 0; b < PIN_W; b++)
                  if ($urandom_range(0, 99) < 30)
                     lv_state[b] = ~lv_state[b];
               lv = lv_state;
            end
            lv_state = lv;
            send_sample(cnt, lv, taken);
            if (taken) begin
               done++;
               total++;
            end
            if ($urandom_range(0, 199) == 0)
               settle();
         end
      end

      settle();
      if (sb.mismatches == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule
